>>> sv/ir_pulse_distance_frame_decoder_assert.svh
// ----------------------------------------------------------------------------
// IR pulse-distance frame decoder assertion macros
// Concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_DISTANCE_FRAME_DECODER_ASSERT_SVH
`define IR_PULSE_DISTANCE_FRAME_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

`define IRPD_ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("irpd assertion failed: never condition seen");

`define IRPD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("irpd assertion failed: next-cycle consequence missing");

`define IRPD_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("irpd assertion failed: same-cycle consequence missing");

`else

`define IRPD_ASSERT_NEVER(label, clk, rstn, expr)
`define IRPD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`define IRPD_ASSERT_SAME(label, clk, rstn, ante, cons)

`endif

`endif

>>> sv/irpd_pkg.sv
// ----------------------------------------------------------------------------
// IR pulse-distance decoder package
// Shared types, widths and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package irpd_pkg;

    localparam int TICK_W  = 15;
    localparam int IDX_W   = 7;
    localparam int BYTES_W = 56;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_THRESHOLD = 1'b1;

    localparam logic [TICK_W-1:0] ONE_THRESHOLD_RST = 15'd500;
    localparam logic [TICK_W-1:0] GAP_THRESHOLD_RST = 15'd1300;

    typedef struct packed {
        logic [TICK_W-1:0] mark_ticks;
        logic [TICK_W-1:0] space_ticks;
        logic              frame_start;
        logic              last_item;
    } item_t;

    typedef struct packed {
        logic [TICK_W-1:0] one_threshold;
        logic [TICK_W-1:0] gap_threshold;
    } thresh_t;

    typedef struct packed {
        logic [BYTES_W-1:0] frame_bytes;
        logic               check_error;
        logic [IDX_W-1:0]   bit_positions;
    } result_t;

endpackage

`default_nettype wire

>>> sv/ir_pulse_distance_frame_decoder.sv
// ----------------------------------------------------------------------------
// IR pulse-distance frame decoder
// Decodes mark/space pulse pairs into a bit store and reports each frame.
// ----------------------------------------------------------------------------
// One pulse pair is taken per clock while the decode step is not paused. A
// pair is held in the input register, then the decode step updates the frame
// state and, for the last pair of a frame, loads the result register, which
// drives the result outputs. The single decode step between the input and
// result registers sets the rate of one pair per cycle; it pauses only when a
// last pair meets a result that is still waiting to be taken. The user must
// write thresholds through the cfg port (index 0 one threshold, index 1 gap
// threshold) only while the block is idle; the block does not enforce this.
`default_nettype none

`include "ir_pulse_distance_frame_decoder_assert.svh"

module ir_pulse_distance_frame_decoder #(
    parameter int MAX_BITS = 64
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [irpd_pkg::TICK_W-1:0]        s_mark_ticks,
    input  wire logic [irpd_pkg::TICK_W-1:0]        s_space_ticks,
    input  wire logic                               s_frame_start,
    input  wire logic                               s_last_item,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [irpd_pkg::BYTES_W-1:0]            m_frame_bytes,
    output logic                                    m_check_error,
    output logic [irpd_pkg::IDX_W-1:0]              m_bit_positions,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [irpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [irpd_pkg::TICK_W-1:0]        cfg_data
);

    irpd_pkg::item_t   item_reg;
    logic              in_valid_reg;
    irpd_pkg::thresh_t thresh_reg;

    logic [MAX_BITS-1:0]        store_reg, store_next;
    logic [irpd_pkg::IDX_W-1:0] index_reg, index_next;
    logic                       stopped_reg, stopped_next;

    irpd_pkg::result_t result_reg, step_result;
    logic              m_valid_reg;
    logic              step_go;

    assign step_go   = in_valid_reg && (!item_reg.last_item || !m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || step_go;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg.one_threshold <= irpd_pkg::ONE_THRESHOLD_RST;
            thresh_reg.gap_threshold <= irpd_pkg::GAP_THRESHOLD_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                irpd_pkg::REG_ONE_THRESHOLD: thresh_reg.one_threshold <= cfg_data;
                irpd_pkg::REG_GAP_THRESHOLD: thresh_reg.gap_threshold <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.mark_ticks  <= s_mark_ticks;
            item_reg.space_ticks <= s_space_ticks;
            item_reg.frame_start <= s_frame_start;
            item_reg.last_item   <= s_last_item;
        end
    end

    irpd_step #(
        .MAX_BITS (MAX_BITS)
    ) u_step (
        .item         (item_reg),
        .thresh       (thresh_reg),
        .store_cur    (store_reg),
        .index_cur    (index_reg),
        .stopped_cur  (stopped_reg),
        .store_next   (store_next),
        .index_next   (index_next),
        .stopped_next (stopped_next),
        .result       (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            store_reg   <= '0;
            index_reg   <= '0;
            stopped_reg <= 1'b0;
        end else if (step_go) begin
            store_reg   <= store_next;
            index_reg   <= index_next;
            stopped_reg <= stopped_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_go && item_reg.last_item) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_go && item_reg.last_item) begin
            result_reg <= step_result;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_frame_bytes   = result_reg.frame_bytes;
    assign m_check_error   = result_reg.check_error;
    assign m_bit_positions = result_reg.bit_positions;

    `IRPD_ASSERT_NEVER(a_index_bound, aclk, aresetn, index_reg > irpd_pkg::IDX_W'(MAX_BITS))
    `IRPD_ASSERT_NEXT(a_last_emits, aclk, aresetn, step_go && item_reg.last_item, m_valid_reg)
    `IRPD_ASSERT_NEXT(a_last_clears, aclk, aresetn, step_go && item_reg.last_item,
                      index_reg == '0 && !stopped_reg)
    `IRPD_ASSERT_SAME(a_no_overrun, aclk, aresetn,
                      m_valid_reg && !m_ready && in_valid_reg && item_reg.last_item, !step_go)

endmodule

`default_nettype wire

>>> sv/irpd_check.sv
// ----------------------------------------------------------------------------
// IR pulse-distance frame check
// Nibble parity of bytes 0..1 vs byte 2[3:0]; no common set bits in 3/4, 5/6.
// ----------------------------------------------------------------------------
`default_nettype none

module irpd_check (
    input  wire logic [irpd_pkg::BYTES_W-1:0] frame_bytes,
    output logic                              check_error
);

    logic [7:0] b0, b1, b2, b3, b4, b5, b6;
    logic [3:0] nib;

    always_comb begin
        b0  = frame_bytes[7:0];
        b1  = frame_bytes[15:8];
        b2  = frame_bytes[23:16];
        b3  = frame_bytes[31:24];
        b4  = frame_bytes[39:32];
        b5  = frame_bytes[47:40];
        b6  = frame_bytes[55:48];
        nib = b0[7:4] ^ b0[3:0] ^ b1[7:4] ^ b1[3:0];
        check_error = (nib != b2[3:0]) || ((b3 & b4) != 8'd0) || ((b5 & b6) != 8'd0);
    end

endmodule

`default_nettype wire

>>> sv/irpd_step.sv
// ----------------------------------------------------------------------------
// IR pulse-distance decode step
// Next frame state and result for one registered pulse pair.
// ----------------------------------------------------------------------------
`default_nettype none

module irpd_step #(
    parameter int MAX_BITS = 64
) (
    input  wire irpd_pkg::item_t                item,
    input  wire irpd_pkg::thresh_t              thresh,
    input  wire logic [MAX_BITS-1:0]            store_cur,
    input  wire logic [irpd_pkg::IDX_W-1:0]     index_cur,
    input  wire logic                           stopped_cur,
    output logic      [MAX_BITS-1:0]            store_next,
    output logic      [irpd_pkg::IDX_W-1:0]     index_next,
    output logic                                stopped_next,
    output irpd_pkg::result_t                   result
);

    localparam int POS_W = $clog2(MAX_BITS);
    localparam logic [irpd_pkg::IDX_W-1:0] LIMIT = irpd_pkg::IDX_W'(MAX_BITS);
    localparam logic [MAX_BITS-1:0] ONE_HOT = {{(MAX_BITS-1){1'b0}}, 1'b1};

    logic [MAX_BITS-1:0]        base_store, work_store;
    logic [irpd_pkg::IDX_W-1:0] base_index, skip_index, work_index;
    logic                       base_stopped, work_stopped;
    logic                       err;

    always_comb begin
        base_store   = item.frame_start ? '0 : store_cur;
        base_index   = item.frame_start ? '0 : index_cur;
        base_stopped = item.frame_start ? 1'b0 : stopped_cur;

        work_store   = base_store;
        work_index   = base_index;
        work_stopped = base_stopped;
        skip_index   = base_index;

        if (!item.frame_start && !base_stopped) begin
            if (item.mark_ticks == '0 || item.space_ticks == '0) begin
                work_stopped = 1'b1;
            end else begin
                if (item.space_ticks > thresh.gap_threshold && base_index < LIMIT) begin
                    skip_index = base_index + 1'b1;
                end
                if (item.space_ticks > thresh.one_threshold && skip_index < LIMIT) begin
                    work_store = base_store | (ONE_HOT << skip_index[POS_W-1:0]);
                end
                work_index = (skip_index < LIMIT) ? skip_index + 1'b1 : skip_index;
            end
        end

        result.frame_bytes   = work_store[irpd_pkg::BYTES_W-1:0];
        result.check_error   = err;
        result.bit_positions = work_index;

        if (item.last_item) begin
            store_next   = '0;
            index_next   = '0;
            stopped_next = 1'b0;
        end else begin
            store_next   = work_store;
            index_next   = work_index;
            stopped_next = work_stopped;
        end
    end

    irpd_check u_check (
        .frame_bytes (work_store[irpd_pkg::BYTES_W-1:0]),
        .check_error (err)
    );

endmodule

`default_nettype wire

>>> verif/tb_ir_pulse_distance_frame_decoder.sv
// ----------------------------------------------------------------------------
// IR pulse-distance frame decoder testbench
// Sends pulse-pair beats in random bursts while the result side stalls on a
// pattern. A local decoder model predicts each frame report, and every result
// beat is checked field by field. The thresholds are stepped through typical,
// zero, full-scale and crossed settings.
// ----------------------------------------------------------------------------
module tb_ir_pulse_distance_frame_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BITS     = 64;
    localparam int DRAIN_CYCLES = 6;
    localparam int IDLE_LIMIT   = 2000;
    localparam int PHASE_BEATS  = 185;
    localparam int N_PHASES     = 8;
    localparam logic [irpd_pkg::TICK_W-1:0] TICK_MAX = '1;

    logic                           aclk          = 1'b0;
    logic                           aresetn       = 1'b0;
    logic                           s_valid       = 1'b0;
    logic                           s_ready;
    logic [irpd_pkg::TICK_W-1:0]    s_mark_ticks  = '0;
    logic [irpd_pkg::TICK_W-1:0]    s_space_ticks = '0;
    logic                           s_frame_start = 1'b0;
    logic                           s_last_item   = 1'b0;
    logic                           m_valid;
    logic                           m_ready       = 1'b0;
    logic [irpd_pkg::BYTES_W-1:0]   m_frame_bytes;
    logic                           m_check_error;
    logic [irpd_pkg::IDX_W-1:0]     m_bit_positions;
    logic                           cfg_valid     = 1'b0;
    logic                           cfg_ready;
    logic [irpd_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
    logic [irpd_pkg::TICK_W-1:0]    cfg_data      = '0;

    irpd_pkg::item_t   pulse_q[$];
    irpd_pkg::result_t frames_due[$];
    int      beats_queued  = 0;
    int      beats_taken   = 0;
    logic    in_taken      = 1'b0;
    int      burst_left    = 1;
    int      gap_left      = 0;
    int      max_gap       = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    logic [3:0]  rdy_phase     = '0;

    logic [irpd_pkg::TICK_W-1:0] cur_one = irpd_pkg::ONE_THRESHOLD_RST;
    logic [irpd_pkg::TICK_W-1:0] cur_gap = irpd_pkg::GAP_THRESHOLD_RST;

    logic [63:0]                 frame_bits = '0;
    logic [irpd_pkg::IDX_W-1:0]  bit_pos    = '0;
    logic                        halted     = 1'b0;
    logic [irpd_pkg::TICK_W-1:0] thr_one    = irpd_pkg::ONE_THRESHOLD_RST;
    logic [irpd_pkg::TICK_W-1:0] thr_gap    = irpd_pkg::GAP_THRESHOLD_RST;

    int mismatches    = 0;
    int reports_seen  = 0;
    int error_reports = 0;
    int full_reports  = 0;
    int reg_writes    = 0;
    int idle_cycles   = 0;

    ir_pulse_distance_frame_decoder #(
        .MAX_BITS(MAX_BITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mark_ticks   (s_mark_ticks),
        .s_space_ticks  (s_space_ticks),
        .s_frame_start  (s_frame_start),
        .s_last_item    (s_last_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_bytes  (m_frame_bytes),
        .m_check_error  (m_check_error),
        .m_bit_positions(m_bit_positions),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < 40) begin
            $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        end
        mismatches++;
    endtask

    task automatic clear_frame();
        frame_bits = '0;
        bit_pos    = '0;
        halted     = 1'b0;
    endtask

    task automatic step_position();
        if (bit_pos < MAX_BITS) begin
            bit_pos = bit_pos + 1'b1;
        end
    endtask

    task automatic decode_pair(input irpd_pkg::item_t pair);
        irpd_pkg::result_t rep;
        logic [3:0]        nib;
        if (pair.frame_start) begin
            clear_frame();
        end else if (!halted) begin
            if (pair.mark_ticks == '0 || pair.space_ticks == '0) begin
                halted = 1'b1;
            end else begin
                if (pair.space_ticks > thr_gap) begin
                    step_position();
                end
                if (pair.space_ticks > thr_one && bit_pos < MAX_BITS) begin
                    frame_bits[bit_pos[5:0]] = 1'b1;
                end
                step_position();
            end
        end
        if (pair.last_item) begin
            nib = frame_bits[3:0] ^ frame_bits[7:4] ^ frame_bits[11:8] ^ frame_bits[15:12];
            rep.frame_bytes   = frame_bits[irpd_pkg::BYTES_W-1:0];
            rep.check_error   = (nib != frame_bits[19:16])
                                || ((frame_bits[31:24] & frame_bits[39:32]) != '0)
                                || ((frame_bits[47:40] & frame_bits[55:48]) != '0);
            rep.bit_positions = bit_pos;
            frames_due.push_back(rep);
            clear_frame();
        end
    endtask

    // Pick a space length that lands in the wanted class under the current
    // thresholds; fall back to any nonzero length when the class is empty.
    function automatic logic [irpd_pkg::TICK_W-1:0] pick_space(input logic one_bit,
                                                               input logic skip);
        int one_i;
        int gap_i;
        int lo;
        int hi;
        one_i = cur_one;
        gap_i = cur_gap;
        if (skip) begin
            lo = (one_bit && one_i > gap_i) ? one_i + 1 : gap_i + 1;
            hi = one_bit ? 32767 : one_i;
        end else begin
            lo = one_bit ? one_i + 1 : 1;
            hi = (one_bit || gap_i < one_i) ? gap_i : one_i;
        end
        if (lo > hi) begin
            return irpd_pkg::TICK_W'($urandom_range(1, 32767));
        end
        return irpd_pkg::TICK_W'($urandom_range(lo, hi));
    endfunction

    function automatic logic [irpd_pkg::TICK_W-1:0] pick_mark();
        if ($urandom_range(0, 9) == 0) begin
            return irpd_pkg::TICK_W'($urandom_range(1, 32767));
        end
        return irpd_pkg::TICK_W'($urandom_range(400, 700));
    endfunction

    task automatic push_beat(input logic [irpd_pkg::TICK_W-1:0] mark,
                             input logic [irpd_pkg::TICK_W-1:0] space,
                             input logic start, input logic last);
        irpd_pkg::item_t b;
        b = '{mark, space, start, last};
        pulse_q.push_back(b);
        beats_queued++;
    endtask

    task automatic queue_frame(input int nbits, input bit with_leader, input bit good_check,
                               input int skip_pct, input int stop_at, input bit trailer_last);
        logic [63:0] payload;
        logic        skip;
        int          i;
        payload = {$urandom, $urandom};
        if (good_check) begin
            payload[19:16] = payload[3:0] ^ payload[7:4] ^ payload[11:8] ^ payload[15:12];
            payload[39:32] = payload[39:32] & ~payload[31:24];
            payload[55:48] = payload[55:48] & ~payload[47:40];
        end
        if (with_leader) begin
            push_beat(irpd_pkg::TICK_W'($urandom_range(8000, 9500)),
                      irpd_pkg::TICK_W'($urandom_range(4000, 4700)), 1'b1, 1'b0);
        end
        for (i = 0; i < nbits; i++) begin
            if (i == stop_at) begin
                if ($urandom_range(0, 1) == 1) begin
                    push_beat('0, pick_space(1'b1, 1'b0), 1'b0, 1'b0);
                end else begin
                    push_beat(pick_mark(), '0, 1'b0, 1'b0);
                end
            end
            skip = ($urandom_range(0, 99) < skip_pct);
            push_beat(pick_mark(), pick_space(payload[i % 64], skip), 1'b0,
                      !trailer_last && i == nbits - 1);
        end
        if (trailer_last || nbits == 0) begin
            push_beat(pick_mark(), '0, 1'b0, 1'b1);
        end
    endtask

    task automatic write_reg(input logic [irpd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [irpd_pkg::TICK_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx == irpd_pkg::REG_ONE_THRESHOLD) begin
            cur_one = val;
        end else begin
            cur_gap = val;
        end
    endtask

    task automatic wait_drained();
        while (beats_taken != beats_queued || frames_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_random(input int quota, input bit squeeze);
        int first;
        int pick;
        int nbits;
        first = beats_queued;
        while (beats_queued - first < quota) begin
            // hold the sender until every pending report is back
            if (squeeze && beats_queued - first >= quota / 2) begin
                wait_drained();
                squeeze = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                nbits = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 72)
                                                    : $urandom_range(8, 56);
                queue_frame(nbits, 1'b1, $urandom_range(0, 1),
                            ($urandom_range(0, 3) == 0) ? 8 : 0, -1,
                            $urandom_range(0, 3) != 0);
            end else if (pick < 82) begin
                queue_frame($urandom_range(0, 40), $urandom_range(0, 1), $urandom_range(0, 1),
                            10, $urandom_range(0, 30), $urandom_range(0, 1));
            end else begin
                push_beat(irpd_pkg::TICK_W'($urandom_range(0, 32767)),
                          irpd_pkg::TICK_W'($urandom_range(0, 32767)),
                          $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
            end
        end
    endtask

    always @(negedge aclk) begin : driver
        irpd_pkg::item_t nxt;
        logic            send;
        send = 1'b0;
        nxt  = '0;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !in_taken)) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
            end else if (pulse_q.size() != 0) begin
                nxt  = pulse_q.pop_front();
                send = 1'b1;
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = (max_gap == 0) ? 0 : $urandom_range(1, max_gap);
                end
            end
            s_valid <= send;
            if (send) begin
                s_mark_ticks  <= nxt.mark_ticks;
                s_space_ticks <= nxt.space_ticks;
                s_frame_start <= nxt.frame_start;
                s_last_item   <= nxt.last_item;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready   <= aresetn && stall_pattern[rdy_phase];
        rdy_phase <= rdy_phase + 1'b1;
    end

    always @(posedge aclk) begin : monitor
        irpd_pkg::result_t want;
        if (!aresetn) begin
            thr_one = irpd_pkg::ONE_THRESHOLD_RST;
            thr_gap = irpd_pkg::GAP_THRESHOLD_RST;
            clear_frame();
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (cfg_valid && cfg_ready) begin
                reg_writes++;
                case (cfg_index)
                    irpd_pkg::REG_ONE_THRESHOLD: thr_one = cfg_data;
                    irpd_pkg::REG_GAP_THRESHOLD: thr_gap = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                reports_seen++;
                if (m_check_error === 1'b1) error_reports++;
                if (m_bit_positions == MAX_BITS) full_reports++;
                if (frames_due.size() == 0) begin
                    report_mismatch("unexpected frame report", 64'(m_frame_bytes), '0);
                end else begin
                    want = frames_due.pop_front();
                    if (m_frame_bytes !== want.frame_bytes) begin
                        report_mismatch("frame_bytes", 64'(m_frame_bytes), 64'(want.frame_bytes));
                    end
                    if (m_check_error !== want.check_error) begin
                        report_mismatch("check_error", 64'(m_check_error), 64'(want.check_error));
                    end
                    if (m_bit_positions !== want.bit_positions) begin
                        report_mismatch("bit_positions", 64'(m_bit_positions),
                                        64'(want.bit_positions));
                    end
                end
            end
            if (s_valid && s_ready) begin
                decode_pair('{s_mark_ticks, s_space_ticks, s_frame_start, s_last_item});
                beats_taken++;
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("ir_pulse_distance_frame_decoder verification failed");
            $finish;
        end
    end

    initial begin
        int                          ph;
        logic [irpd_pkg::TICK_W-1:0] one_v;
        logic [irpd_pkg::TICK_W-1:0] gap_v;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        max_gap       = 3;
        stall_pattern = 16'hB6DB;
        push_beat('0, '0, 1'b1, 1'b1);                      // leader that also ends the frame
        push_beat(TICK_MAX, TICK_MAX, 1'b0, 1'b1);          // lone pair, skip then one
        push_beat(TICK_MAX, TICK_MAX, 1'b1, 1'b0);
        push_beat(15'd560, 15'd1, 1'b0, 1'b0);
        push_beat(15'd560, 15'd500, 1'b0, 1'b0);
        push_beat(15'd560, 15'd501, 1'b0, 1'b0);
        push_beat(15'd560, 15'd1300, 1'b0, 1'b0);
        push_beat(15'd560, 15'd1301, 1'b0, 1'b0);
        push_beat(15'd1, TICK_MAX, 1'b0, 1'b0);
        push_beat('0, 15'd600, 1'b0, 1'b0);                 // trailer on mark
        push_beat(15'd560, 15'd1700, 1'b0, 1'b0);           // dropped after trailer
        push_beat(15'd560, 15'd600, 1'b1, 1'b0);            // leader clears the stop
        push_beat(15'd560, 15'd1690, 1'b0, 1'b0);
        push_beat(15'd560, '0, 1'b0, 1'b1);                 // trailer on space, end frame
        push_beat(15'd560, 15'd1690, 1'b0, 1'b0);           // frame with no leader
        push_beat('0, '0, 1'b0, 1'b1);
        push_beat(TICK_MAX, 15'd1, 1'b0, 1'b1);
        wait_drained();

        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    one_v = irpd_pkg::ONE_THRESHOLD_RST;
                    gap_v = irpd_pkg::GAP_THRESHOLD_RST;
                end
                1: begin one_v = '0;                gap_v = '0;                end
                2: begin one_v = TICK_MAX;          gap_v = TICK_MAX;          end
                3: begin one_v = 15'd1300;          gap_v = 15'd500;           end
                4: begin one_v = '0;                gap_v = TICK_MAX;          end
                5: begin one_v = TICK_MAX;          gap_v = '0;                end
                6: begin
                    one_v = irpd_pkg::TICK_W'($urandom_range(200, 1000));
                    gap_v = one_v + irpd_pkg::TICK_W'($urandom_range(200, 2000));
                end
                default: begin
                    one_v = irpd_pkg::TICK_W'($urandom_range(0, 32767));
                    gap_v = irpd_pkg::TICK_W'($urandom_range(0, 32767));
                end
            endcase
            write_reg(irpd_pkg::REG_ONE_THRESHOLD, one_v);
            write_reg(irpd_pkg::REG_GAP_THRESHOLD, gap_v);
            case (ph % 4)
                0: stall_pattern = 16'hFFFF;
                1: stall_pattern = 16'($urandom) | 16'h0001;
                2: stall_pattern = 16'h0F0F;
                default: stall_pattern = 16'h0001;
            endcase
            max_gap = (ph % 3 == 0) ? 0 : $urandom_range(4, 24);
            run_random(PHASE_BEATS, ph == 3);
            wait_drained();
        end

        if (frames_due.size() != 0) begin
            report_mismatch("frame reports never arrived", 64'(frames_due.size()), '0);
        end
        $display("covered %0d pulse-pair beats and %0d frame reports (%0d flagged, %0d full)",
                 beats_taken, reports_seen, error_reports, full_reports);
        $display("thresholds written %0d times: zero, full-scale, crossed and typical",
                 reg_writes);
        if (mismatches == 0) begin
            $display("ir_pulse_distance_frame_decoder verification clean");
        end else begin
            $display("ir_pulse_distance_frame_decoder verification failed");
        end
        $finish;
    end

endmodule

>>> ir_pulse_distance_frame_decoder.f
+incdir+sv
sv/irpd_pkg.sv
sv/irpd_check.sv
sv/irpd_step.sv
sv/ir_pulse_distance_frame_decoder.sv
verif/tb_ir_pulse_distance_frame_decoder.sv
